### rtl/pse_pkg.sv
package pse_pkg;

	localparam int COORD_W = 16;
	localparam int CFG_W = 12;
	localparam int CFG_IDX_W = 2;
	localparam int SQ_W = 50;
	localparam int LEN_W = 25;
	localparam int NUM_W = 40;
	localparam int DEN_W = 25;
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
	localparam int QDEPTH = 2;
	localparam int NVERT = 6;

	localparam logic [CFG_W-1:0] HALF_WIDTH_RST = 12'd16;
	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST = 12'd800;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 12'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HALF_WIDTH = 2'd0,
		CFG_SCREEN_WIDTH = 2'd1,
		CFG_SCREEN_HEIGHT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic starts_stroke;
	} point_t;

	typedef struct packed {
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic last_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x1;
		logic signed [COORD_W-1:0] y1;
		logic signed [COORD_W-1:0] x2;
		logic signed [COORD_W-1:0] y2;
	} seg_t;

	typedef struct packed {
		logic [CFG_W-1:0] half_width;
		logic [CFG_W-1:0] screen_width;
		logic [CFG_W-1:0] screen_height;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_LOAD,
		BK_SQA,
		BK_SQB,
		BK_SQRT,
		BK_DIVX_S,
		BK_DIVX_W,
		BK_DIVY_S,
		BK_DIVY_W,
		BK_MULX,
		BK_MULY,
		BK_CORN_S,
		BK_CORN_W,
		BK_EMIT
	} bk_state_t;

	// Corner used by each vertex of the two triangles: l1, r1, l2, l2, r1, r2.
	function automatic logic [1:0] corner_of(input logic [2:0] v);
		logic [1:0] c;
		unique case (v)
			3'd0: c = 2'd0;
			3'd1: c = 2'd1;
			3'd2: c = 2'd2;
			3'd3: c = 2'd2;
			3'd4: c = 2'd1;
			3'd5: c = 2'd3;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [29:0] v);
		logic signed [15:0] r;
		if (v > 30'sd32767) r = 16'sh7fff;
		else if (v < -30'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

endpackage

### rtl/pse_front.sv
module pse_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  pse_pkg::point_t in_data,
	output logic push,
	output pse_pkg::seg_t push_seg,
	input  logic q_ready
);
	import pse_pkg::*;

	logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
	logic have_prev_q;
	logic acc;

	assign in_ready = q_ready;
	assign acc = in_valid && in_ready;

	// A point forms a segment only when it continues a stroke and actually moves.
	assign push = acc && !in_data.starts_stroke && have_prev_q &&
		((in_data.point_x != prev_x_q) || (in_data.point_y != prev_y_q));
	assign push_seg = '{x1: prev_x_q, y1: prev_y_q, x2: in_data.point_x, y2: in_data.point_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			have_prev_q <= 1'b0;
		end else if (acc) begin
			prev_x_q <= in_data.point_x;
			prev_y_q <= in_data.point_y;
			have_prev_q <= 1'b1;
		end
	end
endmodule

### rtl/pse_queue.sv
module pse_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pse_pkg::seg_t push_seg,
	output logic q_ready,
	input  logic pop,
	output logic q_valid,
	output pse_pkg::seg_t pop_seg
);
	import pse_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);

	seg_t mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0] count_q;

	assign q_ready = (count_q != (PTR_W+1)'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign pop_seg = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_seg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end
endmodule

### rtl/pse_div.sv
module pse_div (
	input  logic clk,
	input  logic arst_n,
	input  pse_pkg::div_req_t req,
	output pse_pkg::div_rsp_t rsp
);
	import pse_pkg::*;

	logic [DEN_W-1:0] den_q, rem_q;
	logic [NUM_W-1:0] nq_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic done_q;
	logic [DEN_W:0] trial;
	logic fits;

	// Restoring division, one quotient bit per cycle, MSB first.
	assign trial = {rem_q, nq_q[NUM_W-1]};
	assign fits = (trial >= {1'b0, den_q});

	assign rsp = '{done: done_q, quo: nq_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			nq_q <= req.num;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			nq_q <= {nq_q[NUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && (cnt_q == DIV_CNT_W'(1));
			if (req.start) cnt_q <= DIV_CNT_W'(DIV_STEPS);
			else if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

### rtl/pse_back.sv
module pse_back (
	input  logic clk,
	input  logic arst_n,
	input  pse_pkg::cfg_t cfg,
	input  logic q_valid,
	input  pse_pkg::seg_t pop_seg,
	output logic pop,
	output pse_pkg::div_req_t div_req,
	input  pse_pkg::div_rsp_t div_rsp,
	output logic out_valid,
	input  logic out_ready,
	output pse_pkg::vertex_t out_data
);
	import pse_pkg::*;

	bk_state_t state_q, state_d;
	seg_t seg_q;
	logic signed [COORD_W:0] dx_q, dy_q;
	logic [33:0] acc_q;
	logic [SQ_W-1:0] sq_n_q, sq_res_q, sq_bit_q, sq_t;
	logic signed [15:0] ux_q, uy_q;
	logic signed [28:0] ox_q, oy_q;
	logic [2:0] k_q;
	logic [2:0] v_q;
	logic signed [15:0] cx_q [4];
	logic signed [15:0] cy_q [4];
	logic out_valid_q;
	vertex_t out_q;
	logic out_free;

	logic [LEN_W-1:0] len;
	logic signed [COORD_W:0] d_sel;
	logic [COORD_W-1:0] d_abs;
	logic [14:0] q_clamp;
	logic signed [15:0] unit_val;

	logic signed [COORD_W-1:0] base_c;
	logic signed [31:0] corner_c;
	logic [31:0] corner_abs;
	logic [CFG_W-1:0] scr;
	logic [27:0] cq;
	logic signed [29:0] cqs, ndc_v;
	logic signed [15:0] ndc_sat;
	logic [1:0] vc;

	assign len = sq_res_q[LEN_W-1:0];
	assign sq_t = sq_res_q + sq_bit_q;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// Unit vector component from the shared divider.
	assign d_sel = (state_q == BK_DIVX_S || state_q == BK_DIVX_W) ? dx_q : dy_q;
	assign d_abs = d_sel[COORD_W] ? COORD_W'(-d_sel) : d_sel[COORD_W-1:0];
	assign q_clamp = (div_rsp.quo > NUM_W'(32767)) ? 15'h7fff : div_rsp.quo[14:0];
	assign unit_val = d_sel[COORD_W] ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});

	// Corner k: bit 2 picks the end point, bit 1 picks the right side, bit 0 picks y.
	always_comb begin
		unique case ({k_q[2], k_q[0]})
			2'b00: base_c = seg_q.x1;
			2'b01: base_c = seg_q.y1;
			2'b10: base_c = seg_q.x2;
			default: base_c = seg_q.y2;
		endcase
	end

	always_comb begin
		logic signed [31:0] base_w, off_w;
		base_w = {base_c[COORD_W-1], base_c, 15'b0};
		off_w = 32'(k_q[0] ? oy_q : ox_q);
		corner_c = k_q[1] ? base_w - off_w : base_w + off_w;
	end

	assign corner_abs = corner_c[31] ? 32'(-corner_c) : corner_c;
	assign scr = k_q[0] ? cfg.screen_height : cfg.screen_width;
	assign cq = div_rsp.quo[27:0];
	assign cqs = corner_c[31] ? -$signed({2'b0, cq}) : $signed({2'b0, cq});
	assign ndc_v = k_q[0] ? 30'sd8192 - cqs : cqs - 30'sd8192;
	assign ndc_sat = sat16(ndc_v);
	assign vc = corner_of(v_q);

	always_comb begin
		logic [CFG_W-1:0] s1;
		s1 = (scr == '0) ? CFG_W'(1) : scr;
		div_req = '{start: 1'b0, num: '0, den: '0};
		unique case (state_q)
			BK_DIVX_S, BK_DIVY_S: begin
				div_req.start = 1'b1;
				div_req.num = {1'b0, d_abs, 23'b0} + NUM_W'(len >> 1);
				div_req.den = len;
			end
			BK_CORN_S: begin
				div_req.start = 1'b1;
				div_req.num = NUM_W'(corner_abs) + NUM_W'({s1, 4'b0});
				div_req.den = DEN_W'({s1, 5'b0});
			end
			default: ;
		endcase
	end

	always_comb begin
		pop = (state_q == BK_IDLE) && q_valid;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (q_valid) state_d = BK_LOAD;
			BK_LOAD: state_d = BK_SQA;
			BK_SQA: state_d = BK_SQB;
			BK_SQB: state_d = BK_SQRT;
			BK_SQRT: if (sq_bit_q[0]) state_d = BK_DIVX_S;
			BK_DIVX_S: state_d = BK_DIVX_W;
			BK_DIVX_W: if (div_rsp.done) state_d = BK_DIVY_S;
			BK_DIVY_S: state_d = BK_DIVY_W;
			BK_DIVY_W: if (div_rsp.done) state_d = BK_MULX;
			BK_MULX: state_d = BK_MULY;
			BK_MULY: state_d = BK_CORN_S;
			BK_CORN_S: state_d = BK_CORN_W;
			BK_CORN_W: if (div_rsp.done) state_d = (k_q == 3'd7) ? BK_EMIT : BK_CORN_S;
			BK_EMIT: if (out_free && v_q == 3'(NVERT - 1)) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: if (q_valid) seg_q <= pop_seg;
			BK_LOAD: begin
				dx_q <= (COORD_W+1)'(seg_q.x2) - (COORD_W+1)'(seg_q.x1);
				dy_q <= (COORD_W+1)'(seg_q.y2) - (COORD_W+1)'(seg_q.y1);
			end
			BK_SQA: acc_q <= 34'(dx_q * dx_q);
			BK_SQB: begin
				sq_n_q <= {acc_q + 34'(dy_q * dy_q), 16'b0};
				sq_res_q <= '0;
				sq_bit_q <= SQ_W'(1) << 48;
			end
			BK_SQRT: begin
				if (sq_n_q >= sq_t) begin
					sq_n_q <= sq_n_q - sq_t;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			BK_DIVX_W: if (div_rsp.done) ux_q <= unit_val;
			BK_DIVY_W: if (div_rsp.done) uy_q <= unit_val;
			BK_MULX: ox_q <= -(29'(uy_q) * $signed({17'b0, cfg.half_width}));
			BK_MULY: begin
				oy_q <= 29'(ux_q) * $signed({17'b0, cfg.half_width});
				k_q <= '0;
			end
			BK_CORN_W: if (div_rsp.done) begin
				if (k_q[0]) cy_q[k_q[2:1]] <= ndc_sat;
				else cx_q[k_q[2:1]] <= ndc_sat;
				k_q <= k_q + 1'b1;
				v_q <= '0;
			end
			BK_EMIT: if (out_free) begin
				out_q <= '{vertex_x: cx_q[vc], vertex_y: cy_q[vc],
					last_vertex: (v_q == 3'(NVERT - 1))};
				v_q <= v_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_EMIT && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

### rtl/polyline_stroke_expander_top.sv
// A point that starts a stroke or repeats the previous point is accepted and gives no vertices.
// A segment point gives its first vertex after the load and squaring states, 25 square-root
// steps, ten passes through the shared divider with the multiply states between them, and an
// output state; the sixth vertex follows the first when the receiver does not stall. Up to two
// segments wait in the queue while the back end works on one; the divider produces one quotient
// bit per cycle. Reset is asynchronous and active low.
module polyline_stroke_expander_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  pse_pkg::point_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output pse_pkg::vertex_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [pse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pse_pkg::CFG_W-1:0] cfg_data
);
	import pse_pkg::*;

	cfg_t cfg_q;
	logic push, pop, q_ready, q_valid;
	seg_t push_seg, pop_seg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{half_width: HALF_WIDTH_RST, screen_width: SCREEN_WIDTH_RST,
				screen_height: SCREEN_HEIGHT_RST};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HALF_WIDTH: cfg_q.half_width <= cfg_data;
				CFG_SCREEN_WIDTH: cfg_q.screen_width <= cfg_data;
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
				default: ;
			endcase
		end
	end

	pse_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.push, .push_seg, .q_ready
	);

	pse_queue u_queue (
		.clk, .arst_n, .push, .push_seg, .q_ready, .pop, .q_valid, .pop_seg
	);

	pse_div u_div (
		.clk, .arst_n, .req(div_req), .rsp(div_rsp)
	);

	pse_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_valid, .pop_seg, .pop,
		.div_req, .div_rsp, .out_valid, .out_ready, .out_data
	);
endmodule

### rtl/pse_checker.sv
module pse_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input pse_pkg::point_t in_data,
	input logic out_valid,
	input logic out_ready,
	input pse_pkg::vertex_t out_data,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [pse_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pse_pkg::CFG_W-1:0] cfg_data
);
	// A stalled vertex holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled vertex changed");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("vertex offered during reset");

	// The six vertices of a segment leave without gaps once the first is out.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_vertex |=> out_valid)
		else $error("gap inside a vertex burst");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration write stalled");
endmodule

bind polyline_stroke_expander_top pse_checker u_chk (.*);
